>>> rtl/clcd_pkg.sv
// Shared types, codes and the microcode ROM for the character LCD nibble sequencer.
// No dependencies; used by clcd_seq, clcd_dp and char_lcd_nibble_sequencer.
package clcd_pkg;

    localparam int NUM_STEPS = 14;
    localparam int STEP_W    = 4;

    // command opcodes
    localparam logic [2:0] OP_RAW    = 3'd0;
    localparam logic [2:0] OP_PRINT  = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_PULSE       = 2'd0;
    localparam logic [1:0] CFG_CHAR_SETTLE = 2'd1;
    localparam logic [1:0] CFG_CLR_SETTLE  = 2'd2;

    localparam logic [15:0] PULSE_RST       = 16'd500;
    localparam logic [15:0] CHAR_SETTLE_RST = 16'd500;
    localparam logic [15:0] CLR_SETTLE_RST  = 16'd1400;

    localparam logic [15:0] HOLD_POWER_UP = 16'd40000;
    localparam logic [15:0] HOLD_4500     = 16'd4500;
    localparam logic [15:0] HOLD_110      = 16'd110;
    localparam logic [15:0] HOLD_50       = 16'd50;

    localparam logic [7:0] CURSOR_BASE = 8'h80;

    // program entry points
    localparam logic [STEP_W-1:0] EP_RAW    = 4'd0;
    localparam logic [STEP_W-1:0] EP_PRINT  = 4'd1;
    localparam logic [STEP_W-1:0] EP_INIT   = 4'd2;
    localparam logic [STEP_W-1:0] EP_CLEAR  = 4'd11;
    localparam logic [STEP_W-1:0] EP_CURSOR = 4'd13;

    typedef enum logic [1:0] {BYTE_IN, BYTE_CONST, BYTE_CURSOR} byte_sel_t;
    typedef enum logic [1:0] {RS_ZERO, RS_ONE, RS_IN} rs_sel_t;
    typedef enum logic [2:0] {
        SETL_IN, SETL_CHAR, SETL_CLEAR, SETL_4500, SETL_110, SETL_50
    } settle_sel_t;

    // one control word per byte write (or the single power-up idle phase)
    typedef struct packed {
        logic        idle;
        logic        fin;
        byte_sel_t   byte_sel;
        logic [7:0]  const_byte;
        rs_sel_t     rs_sel;
        settle_sel_t settle_sel;
    } ucode_t;

    typedef struct packed {
        logic        in_load;
        logic        load;
        logic [1:0]  phase;
        ucode_t      uc;
    } dp_ctrl_t;

    function automatic ucode_t uw(input logic idle, input logic fin,
                                  input byte_sel_t bsel, input logic [7:0] cbyte,
                                  input rs_sel_t rsel, input settle_sel_t ssel);
        ucode_t w;
        w.idle       = idle;
        w.fin        = fin;
        w.byte_sel   = bsel;
        w.const_byte = cbyte;
        w.rs_sel     = rsel;
        w.settle_sel = ssel;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            4'd0:    w = uw(1'b0, 1'b1, BYTE_IN,     8'h00, RS_IN,   SETL_IN);
            4'd1:    w = uw(1'b0, 1'b1, BYTE_IN,     8'h00, RS_ONE,  SETL_CHAR);
            4'd2:    w = uw(1'b1, 1'b0, BYTE_CONST,  8'h00, RS_ZERO, SETL_CHAR);
            4'd3:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h03, RS_ZERO, SETL_4500);
            4'd4:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h03, RS_ZERO, SETL_110);
            4'd5:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h03, RS_ZERO, SETL_50);
            4'd6:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h02, RS_ZERO, SETL_50);
            4'd7:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h28, RS_ZERO, SETL_CHAR);
            4'd8:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h0C, RS_ZERO, SETL_CHAR);
            4'd9:    w = uw(1'b0, 1'b0, BYTE_CONST,  8'h01, RS_ZERO, SETL_CHAR);
            4'd10:   w = uw(1'b0, 1'b1, BYTE_CONST,  8'h06, RS_ZERO, SETL_CHAR);
            4'd11:   w = uw(1'b0, 1'b0, BYTE_CONST,  8'h01, RS_ZERO, SETL_CLEAR);
            // home: column 0, line 1
            4'd12:   w = uw(1'b0, 1'b1, BYTE_CONST,  8'h80, RS_ZERO, SETL_CHAR);
            4'd13:   w = uw(1'b0, 1'b1, BYTE_CURSOR, 8'h00, RS_ZERO, SETL_CHAR);
            default: w = uw(1'b0, 1'b1, BYTE_CONST,  8'h00, RS_ZERO, SETL_CHAR);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer (HD44780, 4-bit bus).
// Depends on clcd_pkg, clcd_seq and clcd_dp.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: opcode, byte_value, reg_select, settle_us, cursor_x, cursor_y
//  m_axis    | out       | tdata: pin_rs, pin_data, pin_enable, hold_us; tlast: last_phase
//  cfg       | in        | cfg_index 0 pulse, 1 char settle, 2 clear settle; no read-back
//
// One phase beat leaves per cycle while the output is taken: 4 beats for raw write,
// print and cursor move, 8 for clear, 33 for init; the microcode step and phase
// counters set this. A command is taken only when the previous one has issued its
// last phase; its first beat is loaded once the sequencer is busy. Undefined opcodes
// are accepted and give no beats. Reset restores the register defaults; no clearing pass.
module char_lcd_nibble_sequencer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] opcode, [10:3] byte_value, [11] reg_select, [27:12] settle_us,
    // [35:28] cursor_x, [43:36] cursor_y, [47:44] zero
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] pin_rs, [4:1] pin_data, [5] pin_enable, [21:6] hold_us, [23:22] zero
    output logic [23:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    clcd_pkg::dp_ctrl_t ctrl;
    logic               pin_rs;
    logic [3:0]         pin_data;
    logic               pin_enable;
    logic [15:0]        hold_us;

    clcd_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tdata[2:0]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .ctrl      (ctrl)
    );

    clcd_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_value (s_axis_tdata[10:3]),
        .reg_select (s_axis_tdata[11]),
        .settle_us  (s_axis_tdata[27:12]),
        .cursor_x   (s_axis_tdata[35:28]),
        .cursor_y   (s_axis_tdata[43:36]),
        .ctrl       (ctrl),
        .pin_rs     (pin_rs),
        .pin_data   (pin_data),
        .pin_enable (pin_enable),
        .hold_us    (hold_us),
        .last_phase (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, hold_us, pin_enable, pin_data, pin_rs};

endmodule

>>> rtl/clcd_seq.sv
// Microcode sequencer: step counter, phase counter, entry decode and output valid.
// Depends on clcd_pkg (ROM, entry points, control types).
module clcd_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic                out_ready,
    output logic                out_valid,
    output clcd_pkg::dp_ctrl_t  ctrl
);

    logic                          busy_reg, busy_next;
    logic [clcd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          acc;
    logic                          adv;
    logic                          step_done;
    logic                          ep_ok;
    logic [clcd_pkg::STEP_W-1:0]   ep;
    clcd_pkg::ucode_t              uc;

    assign uc        = clcd_pkg::ucode_rom(step_reg);
    assign in_ready  = !busy_reg;
    assign acc       = in_valid && in_ready;
    assign adv       = busy_reg && (!out_valid_reg || out_ready);
    assign step_done = uc.idle || (phase_reg == 2'd3);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ep_ok = 1'b1;
        ep    = clcd_pkg::EP_RAW;
        unique case (opcode)
            clcd_pkg::OP_RAW:    ep = clcd_pkg::EP_RAW;
            clcd_pkg::OP_PRINT:  ep = clcd_pkg::EP_PRINT;
            clcd_pkg::OP_INIT:   ep = clcd_pkg::EP_INIT;
            clcd_pkg::OP_CLEAR:  ep = clcd_pkg::EP_CLEAR;
            clcd_pkg::OP_CURSOR: ep = clcd_pkg::EP_CURSOR;
            default:             ep_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (acc)
        begin
            // unknown opcodes are taken and dropped
            busy_next  = ep_ok;
            step_next  = ep;
            phase_next = 2'd0;
        end
        else if (adv)
        begin
            out_valid_next = 1'b1;
            if (step_done)
            begin
                phase_next = 2'd0;
                if (uc.fin)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctrl.in_load = acc;
    assign ctrl.load    = adv;
    assign ctrl.phase   = phase_reg;
    assign ctrl.uc      = uc;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg < clcd_pkg::STEP_W'(clcd_pkg::NUM_STEPS)))
        else $error("step counter outside program");

    a_idle_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uc.idle) |-> (phase_reg == 2'd0))
        else $error("idle step ran past its single phase");

    a_end_of_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && uc.fin && step_done) |=> !busy_reg)
        else $error("sequencer still busy after final phase");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && ep_ok) |=> (busy_reg && (step_reg == $past(ep)) && (phase_reg == 2'd0)))
        else $error("command did not start at its entry point");
`endif

endmodule

>>> rtl/clcd_dp.sv
// Datapath: configuration registers, operand latch, cursor address and phase output register.
// Depends on clcd_pkg (control word, constants, register indexes).
module clcd_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [7:0]          byte_value,
    input  logic                reg_select,
    input  logic [15:0]         settle_us,
    input  logic [7:0]          cursor_x,
    input  logic [7:0]          cursor_y,
    input  clcd_pkg::dp_ctrl_t  ctrl,
    output logic                pin_rs,
    output logic [3:0]          pin_data,
    output logic                pin_enable,
    output logic [15:0]         hold_us,
    output logic                last_phase
);

    logic [15:0] pulse_reg, char_settle_reg, clr_settle_reg;
    logic [7:0]  byte_reg;
    logic        rs_reg;
    logic [15:0] settle_reg;
    logic [7:0]  addr_reg;

    logic [3:0]  line_m1;
    logic [7:0]  addr_next;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [15:0] cur_settle;
    logic        cur_en;
    logic [15:0] cur_hold;

    logic        pin_rs_reg, pin_enable_reg, last_reg;
    logic [3:0]  pin_data_reg;
    logic [15:0] hold_reg;

    // address wraps at 8 bits, so only two bits of (line - 1) survive the * 0x40
    assign line_m1   = cursor_y[3:0] - 4'd1;
    assign addr_next = clcd_pkg::CURSOR_BASE + {line_m1[1:0], 6'd0} + {4'd0, cursor_x[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg       <= clcd_pkg::PULSE_RST;
            char_settle_reg <= clcd_pkg::CHAR_SETTLE_RST;
            clr_settle_reg  <= clcd_pkg::CLR_SETTLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clcd_pkg::CFG_PULSE:       pulse_reg       <= cfg_data;
                clcd_pkg::CFG_CHAR_SETTLE: char_settle_reg <= cfg_data;
                clcd_pkg::CFG_CLR_SETTLE:  clr_settle_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_load)
        begin
            byte_reg   <= byte_value;
            rs_reg     <= reg_select;
            settle_reg <= settle_us;
            addr_reg   <= addr_next;
        end
    end

    always_comb
    begin
        unique case (ctrl.uc.byte_sel)
            clcd_pkg::BYTE_IN:     cur_byte = byte_reg;
            clcd_pkg::BYTE_CURSOR: cur_byte = addr_reg;
            default:               cur_byte = ctrl.uc.const_byte;
        endcase
        unique case (ctrl.uc.rs_sel)
            clcd_pkg::RS_ONE: cur_rs = 1'b1;
            clcd_pkg::RS_IN:  cur_rs = rs_reg;
            default:          cur_rs = 1'b0;
        endcase
        unique case (ctrl.uc.settle_sel)
            clcd_pkg::SETL_IN:    cur_settle = settle_reg;
            clcd_pkg::SETL_CLEAR: cur_settle = clr_settle_reg;
            clcd_pkg::SETL_4500:  cur_settle = clcd_pkg::HOLD_4500;
            clcd_pkg::SETL_110:   cur_settle = clcd_pkg::HOLD_110;
            clcd_pkg::SETL_50:    cur_settle = clcd_pkg::HOLD_50;
            default:              cur_settle = char_settle_reg;
        endcase
        // phase bit 0: enable low half; bit 1: low nibble
        cur_en = !ctrl.phase[0] && !ctrl.uc.idle;
        if (ctrl.uc.idle)
        begin
            cur_hold = clcd_pkg::HOLD_POWER_UP;
        end
        else if (cur_en)
        begin
            cur_hold = pulse_reg;
        end
        else
        begin
            cur_hold = cur_settle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pin_rs_reg     <= cur_rs;
            pin_data_reg   <= ctrl.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
            pin_enable_reg <= cur_en;
            hold_reg       <= cur_hold;
            last_reg       <= ctrl.uc.fin && (ctrl.uc.idle || (ctrl.phase == 2'd3));
        end
    end

    assign pin_rs     = pin_rs_reg;
    assign pin_data   = pin_data_reg;
    assign pin_enable = pin_enable_reg;
    assign hold_us    = hold_reg;
    assign last_phase = last_reg;

endmodule
